@@ design/scsh_pkg.sv @@
// Shared types and constants for the swept circle segment hit test.
package scsh_pkg;

    localparam int COORD_W    = 24;
    localparam int RADIUS_W   = 20;
    localparam int TOL_W      = 8;
    localparam int LIM_W      = RADIUS_W + 1;
    localparam int FRAC_BITS  = 8;
    localparam int SCALE_W    = 18;
    localparam int CMP_W      = 66;
    localparam int PIPE_DEPTH = 6;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_CROSS   = 3'd1,
        CAUSE_B_START = 3'd2,
        CAUSE_B_END   = 3'd3,
        CAUSE_A_START = 3'd4,
        CAUSE_A_END   = 3'd5
    } cause_t;

endpackage

@@ design/scsh_near.sv @@
// Six-stage test of whether a point lies closer than a limit to a segment.
module scsh_near import scsh_pkg::*; (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] p_x,
    input  logic signed [COORD_W-1:0] p_y,
    input  logic signed [COORD_W-1:0] v_x,
    input  logic signed [COORD_W-1:0] v_y,
    input  logic signed [COORD_W:0]   q_x,
    input  logic signed [COORD_W:0]   q_y,
    input  logic [LIM_W-1:0]          lim,
    input  logic                      lim_ok,
    output logic                      near
);

    // Stage A: offsets of the point from both segment ends.
    logic signed [25:0] ax_reg, ay_reg, ax_next, ay_next;
    logic signed [26:0] bx_reg, by_reg;
    logic signed [23:0] vxa_reg, vya_reg;
    logic [LIM_W-1:0]   lim_a_reg;
    logic               ok_a_reg;

    // Stage B: products.
    logic signed [49:0] pdax_reg, pday_reg, cr1_reg, cr2_reg;
    logic signed [50:0] pdbx_reg, pdby_reg;
    logic signed [53:0] sqax_reg, sqay_reg, sqbx_reg, sqby_reg;
    logic signed [47:0] vvx_reg, vvy_reg;
    logic [41:0]        lim2_b_reg;
    logic               ok_b_reg;

    // Stage C: sums.
    logic signed [51:0] da_next, db_next;
    logic signed [54:0] la_next, lb_next;
    logic signed [50:0] cd_next;
    logic [50:0]        cabs_next;
    logic [54:0]        d2_reg;
    logic [49:0]        c_reg;
    logic [47:0]        vv_reg;
    logic [41:0]        lim2_c_reg;
    logic               use_end_c_reg, ok_c_reg;

    // Stage D: partial products of the wide comparison.
    logic [49:0] hh_reg, hl_reg, ll_reg;
    logic [44:0] rhh_reg, rhl_reg, rlh_reg, rll_reg;
    logic        end_hit_d_reg, use_end_d_reg, ok_d_reg;

    // Stage E: recombined squares.
    logic [99:0] csq_reg, rv_reg;
    logic        end_hit_e_reg, use_end_e_reg, ok_e_reg;

    logic near_reg;

    assign ax_next = 26'(q_x) - 26'(p_x);
    assign ay_next = 26'(q_y) - 26'(p_y);

    assign da_next   = 52'(pdax_reg) + 52'(pday_reg);
    assign db_next   = 52'(pdbx_reg) + 52'(pdby_reg);
    assign la_next   = 55'(sqax_reg) + 55'(sqay_reg);
    assign lb_next   = 55'(sqbx_reg) + 55'(sqby_reg);
    assign cd_next   = 51'(cr1_reg) - 51'(cr2_reg);
    assign cabs_next = (cd_next < 0) ? 51'(-cd_next) : 51'(cd_next);

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            bx_reg    <= 27'(ax_next) - 27'(v_x);
            by_reg    <= 27'(ay_next) - 27'(v_y);
            vxa_reg   <= v_x;
            vya_reg   <= v_y;
            lim_a_reg <= lim;
            ok_a_reg  <= lim_ok;

            pdax_reg   <= 50'(vxa_reg) * 50'(ax_reg);
            pday_reg   <= 50'(vya_reg) * 50'(ay_reg);
            pdbx_reg   <= 51'(vxa_reg) * 51'(bx_reg);
            pdby_reg   <= 51'(vya_reg) * 51'(by_reg);
            sqax_reg   <= 54'(ax_reg) * 54'(ax_reg);
            sqay_reg   <= 54'(ay_reg) * 54'(ay_reg);
            sqbx_reg   <= 54'(bx_reg) * 54'(bx_reg);
            sqby_reg   <= 54'(by_reg) * 54'(by_reg);
            cr1_reg    <= 50'(vxa_reg) * 50'(ay_reg);
            cr2_reg    <= 50'(vya_reg) * 50'(ax_reg);
            vvx_reg    <= 48'(vxa_reg) * 48'(vxa_reg);
            vvy_reg    <= 48'(vya_reg) * 48'(vya_reg);
            lim2_b_reg <= 42'(lim_a_reg) * 42'(lim_a_reg);
            ok_b_reg   <= ok_a_reg;

            // Distance to the nearer end applies unless the foot of the
            // perpendicular falls strictly inside the segment.
            d2_reg        <= (la_next < lb_next) ? 55'(la_next) : 55'(lb_next);
            use_end_c_reg <= (da_next == 0) || (db_next == 0) ||
                             ((da_next > 0) == (db_next > 0));
            c_reg         <= cabs_next[49:0];
            vv_reg        <= 48'(vvx_reg) + 48'(vvy_reg);
            lim2_c_reg    <= lim2_b_reg;
            ok_c_reg      <= ok_b_reg;

            hh_reg        <= 50'(c_reg[49:25]) * 50'(c_reg[49:25]);
            hl_reg        <= 50'(c_reg[49:25]) * 50'(c_reg[24:0]);
            ll_reg        <= 50'(c_reg[24:0]) * 50'(c_reg[24:0]);
            rhh_reg       <= 45'(lim2_c_reg[41:21]) * 45'(vv_reg[47:24]);
            rhl_reg       <= 45'(lim2_c_reg[41:21]) * 45'(vv_reg[23:0]);
            rlh_reg       <= 45'(lim2_c_reg[20:0]) * 45'(vv_reg[47:24]);
            rll_reg       <= 45'(lim2_c_reg[20:0]) * 45'(vv_reg[23:0]);
            end_hit_d_reg <= d2_reg < 55'(lim2_c_reg);
            use_end_d_reg <= use_end_c_reg;
            ok_d_reg      <= ok_c_reg;

            csq_reg       <= (100'(hh_reg) << 50) + (100'(hl_reg) << 26) + 100'(ll_reg);
            rv_reg        <= (100'(rhh_reg) << 45) + (100'(rhl_reg) << 21) +
                             (100'(rlh_reg) << 24) + 100'(rll_reg);
            end_hit_e_reg <= end_hit_d_reg;
            use_end_e_reg <= use_end_d_reg;
            ok_e_reg      <= ok_d_reg;

            near_reg <= ok_e_reg && (use_end_e_reg ? end_hit_e_reg : (csq_reg < rv_reg));
        end
    end

    assign near = near_reg;

endmodule

@@ design/scsh_cross.sv @@
// Six-stage test of whether the two center segments cross within tolerance.
module scsh_cross import scsh_pkg::*; (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [COORD_W-1:0] a_x,
    input  logic signed [COORD_W-1:0] a_y,
    input  logic signed [COORD_W-1:0] av_x,
    input  logic signed [COORD_W-1:0] av_y,
    input  logic signed [COORD_W-1:0] b_x,
    input  logic signed [COORD_W-1:0] b_y,
    input  logic signed [COORD_W-1:0] bv_x,
    input  logic signed [COORD_W-1:0] bv_y,
    input  logic [TOL_W-1:0]          tol,
    output logic                      crossing
);

    localparam logic [SCALE_W-1:0] ONE = SCALE_W'(1) << FRAC_BITS;

    logic signed [24:0] sx_reg, sy_reg;
    logic signed [23:0] avx_reg, avy_reg, bvx_reg, bvy_reg;
    logic [TOL_W-1:0]   tol_a_reg, tol_b_reg, tol_c_reg, tol_d_reg;

    logic signed [47:0] pd1_reg, pd2_reg;
    logic signed [48:0] pn1a_reg, pn1b_reg, pn2a_reg, pn2b_reg;

    logic signed [48:0] den_reg;
    logic signed [49:0] n1_reg, n2_reg;

    logic signed [50:0] nn1_next, nn2_next;
    logic [49:0]        m1_reg, m2_reg;
    logic [47:0]        d_reg;
    logic               pos1_d_reg, neg1_d_reg, pos2_d_reg, neg2_d_reg, nz_d_reg;

    logic [CMP_W-1:0]   lhs1_reg, lhs2_reg, lo_reg, hi_reg;
    logic               pos1_e_reg, neg1_e_reg, pos2_e_reg, neg2_e_reg, nz_e_reg;

    logic ok1, ok2, cross_reg;

    // Fold the sign of the denominator into the numerators.
    assign nn1_next = (den_reg < 0) ? -51'(n1_reg) : 51'(n1_reg);
    assign nn2_next = (den_reg < 0) ? -51'(n2_reg) : 51'(n2_reg);

    // t in range: -eps*|den| <= n and n <= (1+eps)*|den|, all scaled by one.
    assign ok1 = (!neg1_e_reg || (lhs1_reg <= lo_reg)) && (!pos1_e_reg || (lhs1_reg <= hi_reg));
    assign ok2 = (!neg2_e_reg || (lhs2_reg <= lo_reg)) && (!pos2_e_reg || (lhs2_reg <= hi_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg    <= 25'(a_x) - 25'(b_x);
            sy_reg    <= 25'(a_y) - 25'(b_y);
            avx_reg   <= av_x;
            avy_reg   <= av_y;
            bvx_reg   <= bv_x;
            bvy_reg   <= bv_y;
            tol_a_reg <= tol;

            pd1_reg   <= 48'(bvx_reg) * 48'(avy_reg);
            pd2_reg   <= 48'(bvy_reg) * 48'(avx_reg);
            pn1a_reg  <= 49'(sx_reg) * 49'(bvy_reg);
            pn1b_reg  <= 49'(sy_reg) * 49'(bvx_reg);
            pn2a_reg  <= 49'(sx_reg) * 49'(avy_reg);
            pn2b_reg  <= 49'(sy_reg) * 49'(avx_reg);
            tol_b_reg <= tol_a_reg;

            den_reg   <= 49'(pd1_reg) - 49'(pd2_reg);
            n1_reg    <= 50'(pn1a_reg) - 50'(pn1b_reg);
            n2_reg    <= 50'(pn2a_reg) - 50'(pn2b_reg);
            tol_c_reg <= tol_b_reg;

            m1_reg     <= (nn1_next < 0) ? 50'(-nn1_next) : 50'(nn1_next);
            m2_reg     <= (nn2_next < 0) ? 50'(-nn2_next) : 50'(nn2_next);
            pos1_d_reg <= nn1_next > 0;
            neg1_d_reg <= nn1_next < 0;
            pos2_d_reg <= nn2_next > 0;
            neg2_d_reg <= nn2_next < 0;
            d_reg      <= (den_reg < 0) ? 48'(-den_reg) : 48'(den_reg);
            nz_d_reg   <= den_reg != 0;
            tol_d_reg  <= tol_c_reg;

            lhs1_reg   <= CMP_W'(m1_reg) << FRAC_BITS;
            lhs2_reg   <= CMP_W'(m2_reg) << FRAC_BITS;
            lo_reg     <= CMP_W'(tol_d_reg) * CMP_W'(d_reg);
            hi_reg     <= CMP_W'(ONE + SCALE_W'(tol_d_reg)) * CMP_W'(d_reg);
            pos1_e_reg <= pos1_d_reg;
            neg1_e_reg <= neg1_d_reg;
            pos2_e_reg <= pos2_d_reg;
            neg2_e_reg <= neg2_d_reg;
            nz_e_reg   <= nz_d_reg;

            // Parallel or degenerate paths never count as crossing.
            cross_reg <= nz_e_reg && ok1 && ok2;
        end
    end

    assign crossing = cross_reg;

endmodule

@@ design/swept_circle_segment_hit_test_top.sv @@
// Top level of the swept circle against segment hit test pipeline.
//
// Each input beat on the s_ channel carries one pair: circle A (start,
// motion vector, radius) and segment B (start, direction, radius; radius
// zero means a wall). Each pair yields exactly one output beat on the m_
// channel with m_hit and m_hit_cause (none, crossing, B start, B end,
// A start, A end; the first test that holds wins).
// The tolerance register is written through cfg_we/cfg_wdata and takes
// effect for pairs accepted after the write; it resets to one.
// From acceptance to m_valid a beat passes six pipeline stages in the
// crossing unit and the four distance units, which run side by side,
// plus the output register. One beat is accepted every cycle unless the
// receiver stalls; the rate is set by the fully pipelined multipliers,
// the wide distance squares being split into partial products over two stages.
// Reset (aresetn low, synchronous) clears every valid bit and the output
// valid, so no beat is in flight afterwards. When the receiver stalls with
// a result waiting, the whole pipeline holds and s_ready drops, even if
// earlier stages hold bubbles; nothing is lost or repeated.
module swept_circle_segment_hit_test_top import scsh_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [TOL_W-1:0]           cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [COORD_W-1:0]  s_a_start_x,
    input  logic signed [COORD_W-1:0]  s_a_start_y,
    input  logic signed [COORD_W-1:0]  s_a_move_x,
    input  logic signed [COORD_W-1:0]  s_a_move_y,
    input  logic [RADIUS_W-1:0]        s_a_radius,
    input  logic signed [COORD_W-1:0]  s_b_start_x,
    input  logic signed [COORD_W-1:0]  s_b_start_y,
    input  logic signed [COORD_W-1:0]  s_b_dir_x,
    input  logic signed [COORD_W-1:0]  s_b_dir_y,
    input  logic [RADIUS_W-1:0]        s_b_radius,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic [2:0]                 m_hit_cause
);

    logic [TOL_W-1:0]      tol_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  m_valid_reg;
    logic                  m_hit_reg;
    cause_t                cause_reg;
    cause_t                cause_next;
    logic                  adv;

    logic [LIM_W-1:0]      rsum;
    logic [LIM_W-1:0]      lim;
    logic                  lim_ok;
    logic signed [COORD_W:0] b_end_x, b_end_y, a_end_x, a_end_y;
    logic signed [COORD_W:0] b_start_x_ext, b_start_y_ext, a_start_x_ext, a_start_y_ext;

    logic                  cross_hit;
    logic [3:0]            near_hit;

    // The pipeline moves whenever the output register is empty or drained.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Distance tests only apply while the radius sum exceeds the tolerance.
    assign rsum   = LIM_W'(s_a_radius) + LIM_W'(s_b_radius);
    assign lim_ok = rsum > LIM_W'(tol_reg);
    assign lim    = rsum - LIM_W'(tol_reg);

    assign b_start_x_ext = (COORD_W + 1)'(s_b_start_x);
    assign b_start_y_ext = (COORD_W + 1)'(s_b_start_y);
    assign a_start_x_ext = (COORD_W + 1)'(s_a_start_x);
    assign a_start_y_ext = (COORD_W + 1)'(s_a_start_y);
    assign b_end_x = b_start_x_ext + (COORD_W + 1)'(s_b_dir_x);
    assign b_end_y = b_start_y_ext + (COORD_W + 1)'(s_b_dir_y);
    assign a_end_x = a_start_x_ext + (COORD_W + 1)'(s_a_move_x);
    assign a_end_y = a_start_y_ext + (COORD_W + 1)'(s_a_move_y);

    scsh_cross u_cross (
        .aclk    (aclk),
        .en      (adv),
        .a_x     (s_a_start_x),
        .a_y     (s_a_start_y),
        .av_x    (s_a_move_x),
        .av_y    (s_a_move_y),
        .b_x     (s_b_start_x),
        .b_y     (s_b_start_y),
        .bv_x    (s_b_dir_x),
        .bv_y    (s_b_dir_y),
        .tol     (tol_reg),
        .crossing(cross_hit)
    );

    // B start against the path of A.
    scsh_near u_near_b_start (
        .aclk(aclk), .en(adv),
        .p_x(s_a_start_x), .p_y(s_a_start_y), .v_x(s_a_move_x), .v_y(s_a_move_y),
        .q_x(b_start_x_ext), .q_y(b_start_y_ext),
        .lim(lim), .lim_ok(lim_ok), .near(near_hit[0])
    );

    // B end against the path of A.
    scsh_near u_near_b_end (
        .aclk(aclk), .en(adv),
        .p_x(s_a_start_x), .p_y(s_a_start_y), .v_x(s_a_move_x), .v_y(s_a_move_y),
        .q_x(b_end_x), .q_y(b_end_y),
        .lim(lim), .lim_ok(lim_ok), .near(near_hit[1])
    );

    // A start against segment B.
    scsh_near u_near_a_start (
        .aclk(aclk), .en(adv),
        .p_x(s_b_start_x), .p_y(s_b_start_y), .v_x(s_b_dir_x), .v_y(s_b_dir_y),
        .q_x(a_start_x_ext), .q_y(a_start_y_ext),
        .lim(lim), .lim_ok(lim_ok), .near(near_hit[2])
    );

    // A end against segment B.
    scsh_near u_near_a_end (
        .aclk(aclk), .en(adv),
        .p_x(s_b_start_x), .p_y(s_b_start_y), .v_x(s_b_dir_x), .v_y(s_b_dir_y),
        .q_x(a_end_x), .q_y(a_end_y),
        .lim(lim), .lim_ok(lim_ok), .near(near_hit[3])
    );

    // The first test that holds names the cause.
    always_comb begin
        priority if (cross_hit)   cause_next = CAUSE_CROSS;
        else if (near_hit[0])     cause_next = CAUSE_B_START;
        else if (near_hit[1])     cause_next = CAUSE_B_END;
        else if (near_hit[2])     cause_next = CAUSE_A_START;
        else if (near_hit[3])     cause_next = CAUSE_A_END;
        else                      cause_next = CAUSE_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= TOL_W'(1);
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            if (adv) begin
                vld_reg     <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
                m_valid_reg <= vld_reg[PIPE_DEPTH-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cause_reg <= cause_next;
            m_hit_reg <= cause_next != CAUSE_NONE;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_hit_cause = cause_reg;

    // The hit flag and the cause of a shown result always agree.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_hit_reg == (cause_reg != CAUSE_NONE)))
        else $error("hit flag disagrees with cause");

    // A stalled pipeline keeps every valid bit in place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // The last pipeline stage is what reaches the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (m_valid_reg == $past(vld_reg[PIPE_DEPTH-1])))
        else $error("output valid lost or invented");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the swept circle against segment hit test.
module tb_top;
    import scsh_pkg::*;

    // One pair of shapes, as carried by one input beat.
    typedef struct {
        logic signed [COORD_W-1:0] ax, ay, amx, amy;
        logic [RADIUS_W-1:0]       ar;
        logic signed [COORD_W-1:0] bx, by, bdx, bdy;
        logic [RADIUS_W-1:0]       br;
    } shape_pair_t;

    // A row of the directed table: the expected cause is typed in only when known is set.
    typedef struct {
        shape_pair_t pair;
        bit          known;
        cause_t      want;
    } pair_row_t;

    localparam int  N_RANDOM    = 1600;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 20;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [TOL_W-1:0]          cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_a_start_x = '0, s_a_start_y = '0;
    logic signed [COORD_W-1:0] s_a_move_x = '0, s_a_move_y = '0;
    logic [RADIUS_W-1:0]       s_a_radius = '0;
    logic signed [COORD_W-1:0] s_b_start_x = '0, s_b_start_y = '0;
    logic signed [COORD_W-1:0] s_b_dir_x = '0, s_b_dir_y = '0;
    logic [RADIUS_W-1:0]       s_b_radius = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_hit;
    logic [2:0]                m_hit_cause;

    // Model copy of the tolerance register and the causes still to come out.
    logic [TOL_W-1:0] tol_shadow;
    cause_t           cause_queue[$];
    int               errors = 0;
    int               results_seen = 0;
    int               hits_seen = 0;
    int               cycles = 0;
    int               long_stall = 0;
    bit               stall_free = 1'b0;

    swept_circle_segment_hit_test_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_a_start_x (s_a_start_x),
        .s_a_start_y (s_a_start_y),
        .s_a_move_x  (s_a_move_x),
        .s_a_move_y  (s_a_move_y),
        .s_a_radius  (s_a_radius),
        .s_b_start_x (s_b_start_x),
        .s_b_start_y (s_b_start_y),
        .s_b_dir_x   (s_b_dir_x),
        .s_b_dir_y   (s_b_dir_y),
        .s_b_radius  (s_b_radius),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_hit_cause (m_hit_cause)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // True when point q lies closer than lim to the segment p + [0,1] v.
    // Every comparison is exact: squared lengths, and a 128-bit cross product test.
    function automatic bit point_near_path(longint px, longint py, longint vx, longint vy,
                                           longint qx, longint qy, longint lim);
        longint      ax, ay, bx, by, da, db, la, lb, lim2, cr, vv;
        logic [127:0] cr_w, lhs, rhs;
        ax = qx - px;
        ay = qy - py;
        bx = ax - vx;
        by = ay - vy;
        da = vx * ax + vy * ay;
        db = vx * bx + vy * by;
        lim2 = lim * lim;
        if (da == 0 || db == 0 || ((da > 0) == (db > 0))) begin
            // The nearest point is an endpoint of the path.
            la = ax * ax + ay * ay;
            lb = bx * bx + by * by;
            return ((la < lb) ? la : lb) < lim2;
        end
        // The nearest point is inside the path: compare cross^2 with lim^2 * |v|^2.
        cr = vx * ay - vy * ax;
        if (cr < 0) cr = -cr;
        vv = vx * vx + vy * vy;
        cr_w = 128'(cr);
        lhs = cr_w * cr_w;
        rhs = 128'(lim2) * 128'(vv);
        return lhs < rhs;
    endfunction

    // True when num/den lies in [-tol, 1 + tol] in units of 2^-8, without a division.
    function automatic bit param_within(longint num, longint den, longint tol);
        longint d, n;
        bit     low_ok, high_ok;
        d = (den < 0) ? -den : den;
        n = (den < 0) ? -num : num;
        low_ok  = (n >= 0) || ((longint'(1) << FRAC_BITS) * (-n) <= tol * d);
        high_ok = (n <= 0) || ((longint'(1) << FRAC_BITS) * n
                               <= ((longint'(1) << FRAC_BITS) + tol) * d);
        return low_ok && high_ok;
    endfunction

    // First test that holds for the pair, or none.
    function automatic cause_t hit_cause_of(shape_pair_t p, logic [TOL_W-1:0] tol_reg);
        longint apx, apy, avx, avy, bpx, bpy, bvx, bvy, sx, sy, den, rsum, tol, lim;
        apx = p.ax;  apy = p.ay;  avx = p.amx; avy = p.amy;
        bpx = p.bx;  bpy = p.by;  bvx = p.bdx; bvy = p.bdy;
        tol = longint'(tol_reg);
        rsum = longint'(p.ar) + longint'(p.br);
        sx = apx - bpx;
        sy = apy - bpy;
        den = bvx * avy - bvy * avx;
        // Parallel or zero-length paths skip the crossing test.
        if (den != 0 && param_within(sx * bvy - sy * bvx, den, tol)
                     && param_within(sx * avy - sy * avx, den, tol))
            return CAUSE_CROSS;
        if (rsum <= tol)
            return CAUSE_NONE;
        lim = rsum - tol;
        if (point_near_path(apx, apy, avx, avy, bpx, bpy, lim))
            return CAUSE_B_START;
        if (point_near_path(apx, apy, avx, avy, bpx + bvx, bpy + bvy, lim))
            return CAUSE_B_END;
        if (point_near_path(bpx, bpy, bvx, bvy, apx, apy, lim))
            return CAUSE_A_START;
        if (point_near_path(bpx, bpy, bvx, bvy, apx + avx, apy + avy, lim))
            return CAUSE_A_END;
        return CAUSE_NONE;
    endfunction

    function automatic shape_pair_t make_pair(int ax, int ay, int amx, int amy, int ar,
                                              int bx, int by, int bdx, int bdy, int br);
        shape_pair_t p;
        p.ax  = COORD_W'(ax);  p.ay  = COORD_W'(ay);
        p.amx = COORD_W'(amx); p.amy = COORD_W'(amy); p.ar = RADIUS_W'(ar);
        p.bx  = COORD_W'(bx);  p.by  = COORD_W'(by);
        p.bdx = COORD_W'(bdx); p.bdy = COORD_W'(bdy); p.br = RADIUS_W'(br);
        return p;
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random pair: mostly shapes packed close together so every test gets exercised,
    // plus full-range noise, parallel paths and paths of zero length.
    function automatic shape_pair_t random_pair();
        shape_pair_t p;
        int          kind, cx, cy, k;
        kind = $urandom_range(0, 9);
        if (kind <= 1) begin
            p.ax  = COORD_W'($urandom);  p.ay  = COORD_W'($urandom);
            p.amx = COORD_W'($urandom);  p.amy = COORD_W'($urandom);
            p.bx  = COORD_W'($urandom);  p.by  = COORD_W'($urandom);
            p.bdx = COORD_W'($urandom);  p.bdy = COORD_W'($urandom);
            p.ar  = RADIUS_W'($urandom); p.br  = RADIUS_W'($urandom);
            return p;
        end
        cx = spread(1 << 20);
        cy = spread(1 << 20);
        p.ax  = COORD_W'(cx + spread(4096));  p.ay = COORD_W'(cy + spread(4096));
        p.bx  = COORD_W'(cx + spread(4096));  p.by = COORD_W'(cy + spread(4096));
        p.amx = COORD_W'(spread(4096));       p.amy = COORD_W'(spread(4096));
        p.bdx = COORD_W'(spread(4096));       p.bdy = COORD_W'(spread(4096));
        p.ar = RADIUS_W'($urandom_range(0, 1024));
        p.br = ($urandom_range(0, 3) == 0) ? '0 : RADIUS_W'($urandom_range(0, 1024));
        if (kind == 8) begin
            // B runs parallel to A, possibly in the opposite sense.
            k = spread(3);
            p.bdx = COORD_W'(int'(p.amx) * k);
            p.bdy = COORD_W'(int'(p.amy) * k);
        end else if (kind == 9) begin
            p.amx = '0;
            p.amy = '0;
            if ($urandom_range(0, 1)) begin
                p.bdx = '0;
                p.bdy = '0;
            end
        end
        return p;
    endfunction

    // Drives one beat at the falling edge and holds it until it is accepted.
    task automatic send_pair(shape_pair_t p, cause_t want);
        s_valid = 1'b1;
        s_a_start_x = p.ax;  s_a_start_y = p.ay;
        s_a_move_x  = p.amx; s_a_move_y  = p.amy; s_a_radius = p.ar;
        s_b_start_x = p.bx;  s_b_start_y = p.by;
        s_b_dir_x   = p.bdx; s_b_dir_y   = p.bdy; s_b_radius = p.br;
        do @(posedge aclk); while (!s_ready);
        cause_queue = {cause_queue, want};
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Sender gaps: usually none, sometimes short, rarely a long one.
    task automatic sender_gap();
        int roll, n;
        roll = $urandom_range(0, 99);
        n = (roll < 65) ? 0 : (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (n) @(negedge aclk);
    endtask

    // Waits for every expected result, then for the pipeline to settle.
    task automatic drain();
        while (cause_queue.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] value);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        tol_shadow = value;
    endtask

    // Receiver stalls change at the falling edge. Stretches of stall-free operation
    // come and go, so that both full-rate flow and back-pressure are seen.
    always @(negedge aclk) begin
        int roll;
        roll = $urandom_range(0, 99);
        if (roll == 0)
            stall_free = !stall_free;
        // Occasionally a long stall holds ready low.
        if (!stall_free && aresetn && roll == 50)
            long_stall = $urandom_range(10, 40);
        if (!aresetn)
            m_ready = 1'b1;
        else if (long_stall > 0) begin
            m_ready = 1'b0;
            long_stall--;
        end else if (stall_free)
            m_ready = 1'b1;
        else if (!m_ready)
            m_ready = ($urandom_range(0, 99) < 35);
        else
            m_ready = ($urandom_range(0, 99) < 80);
    end

    // Result checker: each beat out is compared with the oldest expected cause.
    always @(posedge aclk) begin
        cause_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_hit) hits_seen++;
            if (cause_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, hit %0b cause %0d",
                         $time, m_hit, m_hit_cause);
            end else begin
                want = cause_queue.pop_front();
                if (m_hit !== (want != CAUSE_NONE)) begin
                    errors++;
                    $display("%0t: hit mismatch, expected %0b actual %0b",
                             $time, want != CAUSE_NONE, m_hit);
                end
                if (m_hit_cause !== want) begin
                    errors++;
                    $display("%0t: hit_cause mismatch, expected %s actual %0d",
                             $time, want.name(), m_hit_cause);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, cause_queue.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        pair_row_t       rows[$];
        pair_row_t       row;
        shape_pair_t     rp;
        logic [TOL_W-1:0] phase_tol[5];
        int              dir_count;

        // Directed table. Known causes are typed in only where they are obvious.
        row.known = 1'b1; row.want = CAUSE_NONE;
        row.pair = make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);               rows = {rows, row};
        row.want = CAUSE_CROSS;
        row.pair = make_pair(-256, 0, 512, 0, 0, 0, -256, 0, 512, 0);     rows = {rows, row};
        // Parallel paths 512 apart with a large combined radius.
        row.want = CAUSE_B_START;
        row.pair = make_pair(0, 0, 1024, 0, 300, 0, 512, 1024, 0, 300);   rows = {rows, row};
        // Both paths of zero length, centers closer than the radius sum.
        row.pair = make_pair(0, 0, 0, 0, 60, 100, 0, 0, 0, 60);           rows = {rows, row};
        row.want = CAUSE_NONE;
        row.pair = make_pair(0, 0, 256, 0, 0, 10000, 10000, 256, 0, 0);   rows = {rows, row};
        row.known = 1'b0;
        // Field extremes.
        row.pair = make_pair(8388607, 8388607, 8388607, 8388607, 1048575,
                             8388607, 8388607, 8388607, 8388607, 1048575); rows = {rows, row};
        row.pair = make_pair(-8388608, -8388608, -8388608, -8388608, 1048575,
                             -8388608, -8388608, -8388608, -8388608, 1048575);
        rows = {rows, row};
        row.pair = make_pair(8388607, -8388608, -8388608, 8388607, 0,
                             -8388608, 8388607, 8388607, -8388608, 1048575);
        rows = {rows, row};
        row.pair = make_pair(-8388608, 8388607, 0, 0, 1048575,
                             8388607, -8388608, 0, 0, 1048575);           rows = {rows, row};
        // Crossing exactly at the end of A, then just past the tolerance margin.
        row.pair = make_pair(0, 0, 256, 0, 0, 256, -256, 0, 512, 0);      rows = {rows, row};
        row.pair = make_pair(0, 0, 256, 0, 0, 258, -256, 0, 512, 0);      rows = {rows, row};
        row.pair = make_pair(0, 0, 256, 0, 0, -2, -256, 0, 512, 0);       rows = {rows, row};
        // End of B, start of A and end of A near the other path.
        row.pair = make_pair(0, 0, 2560, 0, 200, -5000, 2000, 5100, -1800, 100);
        rows = {rows, row};
        row.pair = make_pair(0, 300, 0, 5000, 200, -3000, 0, 6000, 0, 150); rows = {rows, row};
        row.pair = make_pair(0, -5000, 0, 4700, 200, -3000, 0, 6000, 0, 150);
        rows = {rows, row};
        // A wall: B has radius zero, and a wide nearest-point-inside case.
        row.pair = make_pair(-1000, 400, 2000, 0, 500, -3000, 0, 6000, 0, 0);
        rows = {rows, row};
        row.pair = make_pair(100, 700, 0, 0, 400, -3000, 0, 6000, 100, 350);
        rows = {rows, row};

        phase_tol[0] = 8'd0;
        phase_tol[1] = 8'd255;
        phase_tol[2] = TOL_W'($urandom_range(2, 254));
        phase_tol[3] = 8'd128;
        phase_tol[4] = 8'd1;

        // The tolerance register resets to one.
        tol_shadow = 8'd1;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            send_pair(rows[i].pair, rows[i].known ? rows[i].want
                                                  : hit_cause_of(rows[i].pair, tol_shadow));
            sender_gap();
        end
        dir_count = rows.size();

        // Random pairs in phases, each under a new tolerance written while idle.
        // Draining before each write also makes the sender wait for every result.
        foreach (phase_tol[ph]) begin
            drain();
            write_tolerance(phase_tol[ph]);
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                rp = random_pair();
                send_pair(rp, hit_cause_of(rp, tol_shadow));
                sender_gap();
            end
        end

        drain();
        $display("Covered %0d directed pairs at the reset tolerance and %0d random pairs",
                 dir_count, N_RANDOM);
        $display("over 5 written tolerances; %0d result beats checked, %0d of them hits.",
                 results_seen, hits_seen);
        if (errors == 0 && cause_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ files.f @@
design/scsh_pkg.sv
design/scsh_near.sv
design/scsh_cross.sv
design/swept_circle_segment_hit_test_top.sv
tb/sv/tb_top.sv
